@@ src/kbt_pkg.sv @@
// Package for the keyed bin table: status and request codes, field widths.
// No dependencies.
`default_nettype none
package kbt_pkg;
  localparam int KEY_W = 64;
  localparam int KLEN_W = 4;
  localparam int TIME_W = 32;
  localparam int ITEM_W = 32;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_DEL = 2'd1,
    REQ_GET = 2'd2,
    REQ_NOP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_BINFULL  = 2'd3
  } status_t;

  // Broadcast from the controller into every cell.
  typedef struct packed {
    logic             clr_match;   // free the matching cell
    logic             alloc;       // claim the first free cell
    logic             touch;       // stamp matched or claimed cell
    logic             expire;      // free all aged cells
    logic [TIME_W-1:0] now;
    logic [KEY_W-1:0] key;
    logic [KLEN_W-1:0] klen;
  } cell_cmd_t;
endpackage
`default_nettype wire

@@ src/kbt_cell.sv @@
// One bin of the table: key, touch time, items and count.
// Depends on kbt_pkg. Chained through a free-slot claim token.
`default_nettype none
module kbt_cell #(
  parameter int ITEMS = 8,
  parameter int IBITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire kbt_pkg::cell_cmd_t     cmd,
  input  wire logic [31:0]            timeout_len,
  input  wire logic [IBITS-1:0]       item_in,
  input  wire logic                   claim_in,   // no earlier cell free
  output logic                        claim_out,
  output logic                        match,
  output logic                        is_free,
  output logic [$clog2(ITEMS+1)-1:0]  count,
  input  wire logic [$clog2(ITEMS)-1:0] rd_idx,
  output logic [IBITS-1:0]            rd_item
);
  import kbt_pkg::*;
  localparam int CW = $clog2(ITEMS+1);
  localparam int IW = (ITEMS > 1) ? $clog2(ITEMS) : 1;

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [KLEN_W-1:0] klen;
  logic [TIME_W-1:0] ttime;
  logic [IBITS-1:0]  items [ITEMS];
  logic              mine;
  logic              aged;
  logic [TIME_W:0]   tsum;

  assign is_free   = !valid;
  assign match     = valid && key == cmd.key && klen == cmd.klen;
  assign claim_out = claim_in && valid;
  assign mine      = match || (cmd.alloc && claim_in && !valid);
  assign tsum      = {1'b0, ttime} + {1'b0, timeout_len};
  assign aged      = tsum < {1'b0, cmd.now};
  assign rd_item   = items[rd_idx[IW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (cmd.expire) begin
      if (valid && aged) begin
        valid <= 1'b0;
        count <= '0;
      end
    end else if (cmd.clr_match && match) begin
      valid <= 1'b0;
      count <= '0;
    end else if (cmd.touch && mine) begin
      valid <= 1'b1;
      if (!valid) begin
        key  <= cmd.key;
        klen <= cmd.klen;
      end
      ttime <= cmd.now;
      items[valid ? count[IW-1:0] : '0] <= item_in;
      count <= valid ? count + CW'(1) : CW'(1);
    end
  end
endmodule
`default_nettype wire

@@ src/keyed_bin_table_with_timeout.sv @@
// Keyed bin table with aging: top level, controller and row of cells.
// Depends on kbt_pkg and kbt_cell.
// Results: every result except a streamed item is registered in S_ACT, after
// the lookup in S_LOOK; a get streams its N items back to back from S_STREAM.
// A miss, a full table or a full bin returns to idle from S_ACT; any other add,
// delete or empty get, and a get of N items (at most ITEMS_PER_KEY) after its
// stream, passes through the expiry sweep state S_EXP before idle.
// busy covers the whole span; a new start is taken only in S_IDLE.
// Reset (rst, synchronous) empties every bin; the receiver cannot stall.
`default_nettype none
module keyed_bin_table_with_timeout #(
  parameter int MAX_KEYS      = 16,
  parameter int ITEMS_PER_KEY = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] key_bytes,
  input  wire logic [3:0]  key_len,
  input  wire logic [31:0] item_value,
  input  wire logic [31:0] now,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       status,
  output logic [31:0]      out_item,
  output logic [3:0]       bin_count,
  output logic             last
);
  import kbt_pkg::*;
  localparam int CW = $clog2(ITEMS_PER_KEY+1);
  localparam int IW = (ITEMS_PER_KEY > 1) ? $clog2(ITEMS_PER_KEY) : 1;
  localparam int NW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_ACT    = 5'b00100,
    S_STREAM = 5'b01000,
    S_EXP    = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] timeout_len;
  // Latched transaction.
  req_t              rq;
  logic [KEY_W-1:0]  rkey;
  logic [KLEN_W-1:0] rlen;
  logic [ITEM_W-1:0] ritem;
  logic [TIME_W-1:0] rnow;
  // Lookup results, registered.
  logic          found;
  logic          anyfree;
  logic [NW-1:0] hit;
  logic [CW-1:0] hcount;
  logic [IW-1:0] idx;

  logic [KLEN_W-1:0] len_sat;
  logic [KEY_W-1:0]  kmask;
  cell_cmd_t cmd;
  logic [MAX_KEYS:0]   claim;
  logic [MAX_KEYS-1:0] mvec;
  logic [MAX_KEYS-1:0] fvec;
  logic [CW-1:0]       cnts [MAX_KEYS];
  logic [ITEM_W-1:0]   rds  [MAX_KEYS];
  logic          found_c;
  logic [NW-1:0] hit_c;

  // Saturate the length and mask off bytes beyond it.
  always_comb begin
    len_sat = (key_len > 4'd8) ? 4'd8 : key_len;
    for (int b = 0; b < 8; b++) begin
      kmask[b*8 +: 8] = (4'(b) < len_sat) ? 8'hFF : 8'h00;
    end
  end

  assign claim[0] = 1'b1;
  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.now  = rnow;
    cmd.key  = rkey;
    cmd.klen = rlen;
    if (state == S_ACT) begin
      cmd.clr_match = (rq == REQ_DEL);
      cmd.alloc     = (rq == REQ_ADD) && !found;
      cmd.touch     = (rq == REQ_ADD) && (found ? hcount < CW'(ITEMS_PER_KEY) : anyfree);
    end
    cmd.expire = (state == S_EXP);
  end

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kbt_cell #(.ITEMS(ITEMS_PER_KEY), .IBITS(ITEM_W)) u_cell (
      .clk, .rst, .cmd, .timeout_len,
      .item_in(ritem), .claim_in(claim[g]), .claim_out(claim[g+1]),
      .match(mvec[g]), .is_free(fvec[g]), .count(cnts[g]),
      .rd_idx(idx), .rd_item(rds[g])
    );
  end

  // Keys are unique, so at most one match.
  always_comb begin
    found_c = |mvec;
    hit_c   = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (mvec[i]) hit_c = NW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      timeout_len <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) timeout_len <= cfg_wdata;
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rq    <= req_t'(req_type);
            rkey  <= key_bytes & kmask;
            rlen  <= len_sat;
            ritem <= item_value;
            rnow  <= now;
            if (req_t'(req_type) != REQ_NOP) state <= S_LOOK;
          end
        end
        S_LOOK: begin
          // Hold the match result for the action cycle.
          found   <= found_c;
          hit     <= hit_c;
          hcount  <= cnts[hit_c];
          anyfree <= |fvec;
          idx     <= '0;
          state   <= S_ACT;
        end
        S_ACT: begin
          out_item  <= '0;
          last      <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_EXP;
          unique case (rq)
            REQ_ADD: begin
              if (!found && !anyfree) begin
                status <= ST_FULL; bin_count <= '0; state <= S_IDLE;
              end else if (found && hcount >= CW'(ITEMS_PER_KEY)) begin
                status <= ST_BINFULL; bin_count <= 4'(ITEMS_PER_KEY);
                state <= S_IDLE;
              end else begin
                status <= ST_OK;
                bin_count <= found ? 4'(hcount + CW'(1)) : 4'd1;
              end
            end
            REQ_DEL: begin
              status    <= found ? ST_OK : ST_NOTFOUND;
              bin_count <= found ? 4'(hcount) : 4'd0;
              if (!found) state <= S_IDLE;
            end
            default: begin
              if (!found) begin
                status <= ST_NOTFOUND; bin_count <= '0; state <= S_IDLE;
              end else if (hcount == '0) begin
                status <= ST_OK; bin_count <= '0;
              end else begin
                // Drop this strobe; stream the items instead.
                out_valid <= 1'b0;
                state     <= S_STREAM;
              end
            end
          endcase
        end
        S_STREAM: begin
          out_valid <= 1'b1;
          status    <= ST_OK;
          out_item  <= rds[hit];
          bin_count <= 4'(hcount);
          last      <= (CW'(idx) + CW'(1) == hcount);
          idx       <= idx + IW'(1);
          if (CW'(idx) + CW'(1) == hcount) state <= S_EXP;
        end
        S_EXP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/keyed_bin_table_with_timeout_test.sv @@
// Self-checking testbench for keyed_bin_table_with_timeout: directed table, aging, random runs.
// Depends on kbt_pkg and the keyed_bin_table_with_timeout RTL.
`timescale 1ns / 100ps
`default_nettype none
module keyed_bin_table_with_timeout_test;
  import kbt_pkg::*;

  localparam int NBINS = 16;
  localparam int BIN_DEPTH = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;

  // One result transaction.
  typedef struct {
    status_t     st;
    logic [31:0] item;
    logic [3:0]  cnt;
    logic        lst;
  } bin_result_t;

  // One request transaction, with the checked result where it is obvious.
  typedef struct {
    req_t        req;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [31:0] value;
    logic [31:0] stamp;
    logic        typed;
    status_t     want_st;
    logic [3:0]  want_cnt;
  } request_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [63:0] key_bytes = '0;
  logic [3:0] key_len = '0;
  logic [31:0] item_value = '0;
  logic [31:0] now = '0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] status;
  logic [31:0] out_item;
  logic [3:0] bin_count;
  logic last;

  keyed_bin_table_with_timeout u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .key_bytes(key_bytes), .key_len(key_len),
    .item_value(item_value), .now(now),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .status(status), .out_item(out_item),
    .bin_count(bin_count), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the table.
  logic [31:0] shadow_timeout;
  logic        bin_live [NBINS];
  logic [63:0] bin_key [NBINS];
  logic [3:0]  bin_klen [NBINS];
  logic [31:0] bin_stamp [NBINS];
  logic [3:0]  bin_fill [NBINS];
  logic [31:0] bin_items [NBINS][BIN_DEPTH];

  bin_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  logic [31:0] clock_now = 32'd100;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int lookup_bin(input logic [63:0] key, input logic [3:0] klen);
    for (int i = 0; i < NBINS; i++)
      if (bin_live[i] && bin_klen[i] == klen && bin_key[i] == key) return i;
    return -1;
  endfunction

  // Free every bin whose stamp plus timeout (33-bit sum) is below the time.
  task automatic age_out(input logic [31:0] t);
    for (int i = 0; i < NBINS; i++)
      if (bin_live[i] && ({1'b0, bin_stamp[i]} + {1'b0, shadow_timeout}) < {1'b0, t}) begin
        bin_live[i] = 1'b0;
        bin_fill[i] = '0;
      end
  endtask

  task automatic push_result(input status_t st, input logic [31:0] item,
                             input logic [3:0] cnt, input logic lst);
    bin_result_t r;
    r.st = st; r.item = item; r.cnt = cnt; r.lst = lst;
    pending_results.push_back(r);
  endtask

  // Work out the results of one request and advance the shadow table.
  task automatic predict_table(input req_t req, input logic [63:0] kraw,
                               input logic [3:0] lraw, input logic [31:0] value,
                               input logic [31:0] t);
    logic [3:0] klen;
    logic [63:0] key;
    int b;
    int c;
    klen = (lraw > 4'd8) ? 4'd8 : lraw;
    key = (klen >= 4'd8) ? kraw : (kraw & ((64'd1 << (klen * 8)) - 64'd1));
    b = lookup_bin(key, klen);
    case (req)
      REQ_ADD: begin
        if (b < 0) begin
          for (int i = 0; i < NBINS; i++)
            if (!bin_live[i]) begin
              b = i;
              break;
            end
          if (b < 0) begin
            push_result(ST_FULL, '0, '0, 1'b1);
            return;
          end
          bin_live[b] = 1'b1; bin_key[b] = key; bin_klen[b] = klen; bin_fill[b] = '0;
        end
        c = bin_fill[b];
        if (c >= BIN_DEPTH) begin
          push_result(ST_BINFULL, '0, 4'(BIN_DEPTH), 1'b1);
          return;
        end
        bin_items[b][c] = value;
        bin_fill[b] = 4'(c + 1);
        bin_stamp[b] = t;
        age_out(t);
        push_result(ST_OK, '0, 4'(c + 1), 1'b1);
      end
      REQ_DEL: begin
        if (b < 0) begin
          push_result(ST_NOTFOUND, '0, '0, 1'b1);
          return;
        end
        c = bin_fill[b];
        bin_live[b] = 1'b0; bin_fill[b] = '0;
        age_out(t);
        push_result(ST_OK, '0, 4'(c), 1'b1);
      end
      REQ_GET: begin
        if (b < 0) begin
          push_result(ST_NOTFOUND, '0, '0, 1'b1);
          return;
        end
        c = bin_fill[b];
        if (c == 0) push_result(ST_OK, '0, '0, 1'b1);
        for (int i = 0; i < c; i++)
          push_result(ST_OK, bin_items[b][i], 4'(c), i + 1 == c);
        age_out(t);
      end
      default: ;
    endcase
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result st=%0d item=%h", status, out_item));
      end else begin
        bin_result_t w;
        w = pending_results.pop_front();
        if (status !== w.st)
          report_mismatch($sformatf("status %0d, want %0d", status, w.st));
        if (out_item !== w.item)
          report_mismatch($sformatf("out_item %h, want %h", out_item, w.item));
        if (bin_count !== w.cnt)
          report_mismatch($sformatf("bin_count %0d, want %0d", bin_count, w.cnt));
        if (last !== w.lst)
          report_mismatch($sformatf("last %0d, want %0d", last, w.lst));
      end
    end
  end

  // Watchdog: end the run after too many cycles with no transaction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("keyed_bin_table_with_timeout_test: done, errors");
      $finish;
    end
  end

  // Drive one request; hold start until the block takes the transaction.
  task automatic send_request(input request_row_t row);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct && gap < 20) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    req_type <= row.req;
    key_bytes <= row.key;
    key_len <= row.klen;
    item_value <= row.value;
    now <= row.stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The edge just passed accepted the transaction.
    if (row.typed) begin
      // Typed rows still go through the predictor; compare its first answer.
      int n0;
      n0 = pending_results.size();
      predict_table(row.req, row.key, row.klen, row.value, row.stamp);
      if (pending_results.size() > n0 &&
          (pending_results[n0].st != row.want_st || pending_results[n0].cnt != row.want_cnt))
        report_mismatch("table row disagrees with predictor");
    end else begin
      predict_table(row.req, row.key, row.klen, row.value, row.stamp);
    end
    start <= 1'b0;
    // Hold start low across the next edge so the next drive lands in a new step.
    @(posedge clk);
  endtask

  // Wait until every expected result has arrived, plus the sweep slack.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_timeout = v;
  endtask

  function automatic request_row_t make_row(input req_t req, input logic [63:0] key,
                                            input logic [3:0] klen, input logic [31:0] v,
                                            input logic [31:0] t);
    request_row_t r;
    r.req = req; r.key = key; r.klen = klen; r.value = v; r.stamp = t;
    r.typed = 1'b0; r.want_st = ST_OK; r.want_cnt = '0;
    return r;
  endfunction

  function automatic request_row_t typed_row(input request_row_t r, input status_t st,
                                             input logic [3:0] cnt);
    r.typed = 1'b1; r.want_st = st; r.want_cnt = cnt;
    return r;
  endfunction

  // Random request over a small key pool so bins fill, hit and expire.
  function automatic request_row_t random_row(input int pool);
    request_row_t r;
    logic [63:0] k;
    int pick;
    pick = $urandom_range(99, 0);
    k = {$urandom, $urandom};
    if (pick < 85) k = 64'(($urandom_range(pool - 1, 0)) * 64'h0101_0101_0101_0101) ^ k & 64'hFF;
    r = make_row(req_t'($urandom_range(99, 0) < 55 ? REQ_ADD :
                        ($urandom_range(1, 0) ? REQ_GET : REQ_DEL)),
                 k, 4'($urandom_range(pick < 85 ? 2 : 15, pick < 85 ? 1 : 0)),
                 $urandom, clock_now);
    if ($urandom_range(99, 0) < 3) r.req = REQ_NOP;
    return r;
  endfunction

  request_row_t directed_rows[$];
  request_row_t row;
  int phase_pct [4] = '{0, 61, 0, 29};
  logic [31:0] timeout_choices [4] = '{32'd50, 32'hFFFF_FFFF, 32'd0, 32'd400};

  initial begin
    shadow_timeout = '0;
    for (int i = 0; i < NBINS; i++) begin
      bin_live[i] = 1'b0; bin_fill[i] = '0; bin_key[i] = '0; bin_klen[i] = '0; bin_stamp[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: after-reset misses, extremes, bin full, table full.
    write_timeout(32'hFFFF_FFFF);
    directed_rows.push_back(typed_row(make_row(REQ_GET, 64'h11, 4'd1, 0, 32'd0),
                                      ST_NOTFOUND, 4'd0));
    directed_rows.push_back(typed_row(make_row(REQ_DEL, 64'h11, 4'd1, 0, 32'd0),
                                      ST_NOTFOUND, 4'd0));
    directed_rows.push_back(typed_row(make_row(REQ_ADD, '1, 4'd15, '1, '1), ST_OK, 4'd1));
    directed_rows.push_back(typed_row(make_row(REQ_ADD, '1, 4'd8, '0, '0), ST_OK, 4'd2));
    directed_rows.push_back(typed_row(make_row(REQ_ADD, 64'hABCD, 4'd0, 32'h5A5A, 0),
                                      ST_OK, 4'd1));
    directed_rows.push_back(make_row(REQ_GET, '1, 4'd9, 0, 32'd5));
    directed_rows.push_back(make_row(REQ_GET, 64'h0, 4'd0, 0, 32'd5));
    for (int i = 0; i < 8; i++)
      directed_rows.push_back(make_row(REQ_ADD, 64'h77, 4'd1, 32'hA000_0000 + i, 32'd6));
    directed_rows.push_back(typed_row(make_row(REQ_ADD, 64'h77, 4'd1, 1, 7), ST_BINFULL, 4'd8));
    directed_rows.push_back(make_row(REQ_GET, 64'hFF77, 4'd1, 0, 32'd8));
    directed_rows.push_back(make_row(REQ_NOP, 64'h77, 4'd1, 0, 32'd8));
    directed_rows.push_back(typed_row(make_row(REQ_DEL, 64'h77, 4'd1, 0, 9), ST_OK, 4'd8));
    for (int i = 0; i < 14; i++)
      directed_rows.push_back(make_row(REQ_ADD, 64'h100 + i, 4'd2, i, 32'd10));
    directed_rows.push_back(typed_row(make_row(REQ_ADD, 64'h999, 4'd2, 0, 11), ST_FULL, 4'd0));
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_results();

    // Short timeout: a get far in the future still streams, then every bin stamped before that time ages.
    write_timeout(32'd0);
    send_request(make_row(REQ_GET, 64'h100, 4'd2, 0, 32'hFFFF_FFFF));
    send_request(typed_row(make_row(REQ_GET, 64'h101, 4'd2, 0, 32'hFFFF_FFFF),
                           ST_NOTFOUND, 4'd0));
    drain_results();

    // Random phases, each with its own timeout and idle pattern.
    for (int ph = 0; ph < 4; ph++) begin
      write_timeout(timeout_choices[ph]);
      sender_idle_pct = phase_pct[ph];
      for (int n = 0; n < 86; n++) begin
        clock_now = clock_now + $urandom_range(12, 0);
        row = random_row(ph == 1 ? 20 : 10);
        send_request(row);
        // Hold off once per phase until every result is back.
        if (n == 40) while (pending_results.size() != 0) @(posedge clk);
      end
      drain_results();
    end

    if (error_count == 0)
      $display("keyed_bin_table_with_timeout_test: done, clean");
    else
      $display("keyed_bin_table_with_timeout_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ keyed_bin_table_with_timeout.f @@
src/kbt_pkg.sv
src/kbt_cell.sv
src/keyed_bin_table_with_timeout.sv
tb/sv/keyed_bin_table_with_timeout_test.sv
